/* rtl/pal_pkg.sv */
// Shared constants, codes and types for the positional array list.
`default_nettype none
package pal_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_LOCATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage
`default_nettype wire

/* rtl/pal_if.sv */
// Request and response channel interfaces of the positional array list.
`default_nettype none
interface pal_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [4:0]                    position;
    logic signed [31:0]            value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface pal_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic signed [31:0]            read_value;
    logic [4:0]                    found_position;
    logic [4:0]                    count;
    logic                          is_empty;

    modport source (output valid, ok, read_value, found_position, count, is_empty,
                    input ready);
    modport sink   (input valid, ok, read_value, found_position, count, is_empty,
                    output ready);
endinterface
`default_nettype wire

/* rtl/pal_ram.sv */
// Entry store: one write port, one read port, registered read data.
`default_nettype none
module pal_ram (
    input  wire logic                       clk,
    input  wire pal_pkg::mem_req_t          req,
    output logic [pal_pkg::VAL_W-1:0]       rdata
);

    logic [pal_pkg::VAL_W-1:0] mem [pal_pkg::CAPACITY];
    logic [pal_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/pal_ctrl.sv */
// Command sequencer: range checks, shift/search walk over the store, result register.
`default_nettype none
module pal_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    pal_req_if.sink                         req,
    pal_rsp_if.source                       rsp,
    output pal_pkg::mem_req_t               mem_req,
    input  wire logic [pal_pkg::VAL_W-1:0]  mem_rdata
);

    localparam int ADDR_W = pal_pkg::ADDR_W;
    localparam int CNT_W  = pal_pkg::CNT_W;
    localparam int POS_W  = pal_pkg::POS_W;
    localparam int VAL_W  = pal_pkg::VAL_W;
    localparam int CMP_W  = pal_pkg::CMP_W;

    pal_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic                 issued_reg, issued_next;
    logic                 out_valid_reg, out_valid_next;

    pal_pkg::cmd_t        cmd_reg, cmd_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [ADDR_W-1:0]    ptr_reg, ptr_next;
    logic [ADDR_W-1:0]    last_reg, last_next;
    logic [ADDR_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                 ok_reg, ok_next;
    logic [VAL_W-1:0]     rdv_reg, rdv_next;
    logic [POS_W-1:0]     found_reg, found_next;

    logic                 out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]     out_rdv_reg, out_rdv_next;
    logic [POS_W-1:0]     out_found_reg, out_found_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;

    logic [CMP_W-1:0]     p_ext;
    logic [CMP_W-1:0]     n_ext;
    logic                 walk_stop;

    assign p_ext = CMP_W'(req.position);
    assign n_ext = CMP_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pal_pkg::S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        ok_reg        <= ok_next;
        rdv_reg       <= rdv_next;
        found_reg     <= found_next;
        out_ok_reg    <= out_ok_next;
        out_rdv_reg   <= out_rdv_next;
        out_found_reg <= out_found_next;
        out_cnt_reg   <= out_cnt_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        ptr_next       = ptr_reg;
        last_next      = last_reg;
        pend_addr_next = pend_addr_reg;
        ok_next        = ok_reg;
        rdv_next       = rdv_reg;
        found_next     = found_reg;
        out_ok_next    = out_ok_reg;
        out_rdv_next   = out_rdv_reg;
        out_found_next = out_found_reg;
        out_cnt_next   = out_cnt_reg;
        mem_req        = '0;
        req.ready      = 1'b0;
        walk_stop      = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next    = pal_pkg::cmd_t'(req.command);
                    val_next    = req.value;
                    ok_next     = 1'b0;
                    rdv_next    = '0;
                    found_next  = '0;
                    pend_next   = 1'b0;
                    issued_next = 1'b0;
                    state_next  = pal_pkg::S_DONE;
                    case (pal_pkg::cmd_t'(req.command))
                        pal_pkg::CMD_INSERT:
                        begin
                            if (p_ext >= CMP_W'(1) && p_ext <= n_ext + CMP_W'(1)
                                && n_ext < CMP_W'(pal_pkg::CAPACITY))
                            begin
                                ok_next   = 1'b1;
                                cnt_next  = cnt_reg + CNT_W'(1);
                                last_next = ADDR_W'(p_ext - CMP_W'(1));
                                ptr_next  = ADDR_W'(n_ext - CMP_W'(1));
                                // appending at the tail needs no shift
                                state_next = (p_ext <= n_ext) ? pal_pkg::S_WALK
                                                              : pal_pkg::S_PUT;
                            end
                        end
                        pal_pkg::CMD_DELETE:
                        begin
                            if (p_ext >= CMP_W'(1) && p_ext <= n_ext)
                            begin
                                ok_next   = 1'b1;
                                cnt_next  = cnt_reg - CNT_W'(1);
                                ptr_next  = ADDR_W'(p_ext);
                                last_next = ADDR_W'(n_ext - CMP_W'(1));
                                if (p_ext < n_ext)
                                begin
                                    state_next = pal_pkg::S_WALK;
                                end
                            end
                        end
                        pal_pkg::CMD_READ:
                        begin
                            if (p_ext >= CMP_W'(1) && p_ext <= n_ext)
                            begin
                                ok_next    = 1'b1;
                                ptr_next   = ADDR_W'(p_ext - CMP_W'(1));
                                last_next  = ADDR_W'(p_ext - CMP_W'(1));
                                state_next = pal_pkg::S_WALK;
                            end
                        end
                        default:
                        begin
                            ok_next   = 1'b1;
                            ptr_next  = '0;
                            last_next = ADDR_W'(n_ext - CMP_W'(1));
                            if (cnt_reg != '0)
                            begin
                                state_next = pal_pkg::S_WALK;
                            end
                        end
                    endcase
                end
            end

            pal_pkg::S_WALK:
            begin
                // retire the beat read last cycle, then issue the next read;
                // write and read addresses always differ by two here
                if (pend_reg)
                begin
                    case (cmd_reg)
                        pal_pkg::CMD_INSERT:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = pend_addr_reg + ADDR_W'(1);
                            mem_req.wdata = mem_rdata;
                        end
                        pal_pkg::CMD_DELETE:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = pend_addr_reg - ADDR_W'(1);
                            mem_req.wdata = mem_rdata;
                        end
                        pal_pkg::CMD_READ:
                        begin
                            rdv_next = mem_rdata;
                        end
                        default:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                found_next = POS_W'(CNT_W'(pend_addr_reg) + CNT_W'(1));
                                walk_stop  = 1'b1;
                            end
                        end
                    endcase
                    if (issued_reg)
                    begin
                        walk_stop = 1'b1;
                    end
                end

                pend_next = 1'b0;
                if (!walk_stop && !issued_reg)
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    if (ptr_reg == last_reg)
                    begin
                        issued_next = 1'b1;
                    end
                    else if (cmd_reg == pal_pkg::CMD_INSERT)
                    begin
                        ptr_next = ptr_reg - ADDR_W'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end

                if (walk_stop)
                begin
                    state_next = (cmd_reg == pal_pkg::CMD_INSERT) ? pal_pkg::S_PUT
                                                                  : pal_pkg::S_DONE;
                end
            end

            pal_pkg::S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = last_reg;
                mem_req.wdata = val_reg;
                state_next    = pal_pkg::S_DONE;
            end

            pal_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_rdv_next   = rdv_reg;
                    out_found_next = found_reg;
                    out_cnt_next   = cnt_reg;
                    state_next     = pal_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.read_value     = out_rdv_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.count          = POS_W'(out_cnt_reg);
    assign rsp.is_empty       = (out_cnt_reg == '0);

endmodule
`default_nettype wire

/* rtl/positional_array_list.sv */
// Top level of the positional array list: sequencer plus entry store.
//
// Requests arrive on req (command, position, value) with a valid/ready
// handshake; one response beat per request leaves on rsp (ok, read_value,
// found_position, count, is_empty).
// Requests are handled one at a time. With n entries held, a request does:
//   refused command, delete of last entry, empty locate: no store access
//   append at tail: writes the value;  read: reads entry p
//   insert at position p: shifts entries p..n up by one, then writes the value
//   delete at position p: shifts entries p+1..n down by one
//   locate: compares entries from the first until a match or the end
// Walks over the single-port-pair store move or compare one entry per cycle.
// req.ready is high whenever no request is in flight; a new request may be
// taken while the previous response still waits on a stalled rsp, and the
// block then holds in its final step until the output register frees.
// Reset clears the length to zero and drops any pending response; the
// store itself is not cleared, as only entries below the length are read.
`default_nettype none
module positional_array_list (
    input  wire logic clk,
    input  wire logic rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);

    pal_pkg::mem_req_t          mem_req;
    logic [pal_pkg::VAL_W-1:0]  mem_rdata;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    pal_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

/* rtl/pal_checker.sv */
// Port-level checks on the positional array list, bound to the top level.
`default_nettype none
module pal_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        ok,
    input wire logic [31:0] read_value,
    input wire logic [4:0]  found_position,
    input wire logic [4:0]  count,
    input wire logic        is_empty
);

    // a stalled response beat holds its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(read_value)
            && $stable(found_position) && $stable(count))
        else $error("response changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == 5'd0)))
        else $error("empty flag disagrees with length");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(count) <= 32'(pal_pkg::CAPACITY)))
        else $error("length above capacity");

    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> (read_value == 32'd0) && (found_position == 5'd0))
        else $error("refused command carries data");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (found_position != 5'd0) |-> (found_position <= count)
            && (read_value == 32'd0))
        else $error("match position beyond length");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .ok             (rsp.ok),
    .read_value     (rsp.read_value),
    .found_position (rsp.found_position),
    .count          (rsp.count),
    .is_empty       (rsp.is_empty)
);
`default_nettype wire
